// File: src/cll_pkg.sv
// Shared types and constants for the cursor linked-list engine.
// No dependencies; used by cll_ctrl, cll_dpath and cursor_linked_list_engine.
`timescale 1ns / 1ps

package cll_pkg;

    localparam int NODE_COUNT = 16;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int CNT_W      = $clog2(NODE_COUNT + 1);
    localparam int VAL_W      = 32;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef enum logic [2:0] {
        OP_NEW       = 3'd0,
        OP_CLEAR     = 3'd1,
        OP_APPEND    = 3'd2,
        OP_FIND      = 3'd3,
        OP_FIND_PREV = 3'd4,
        OP_REMOVE    = 3'd5,
        OP_IS_EMPTY  = 3'd6,
        OP_IS_LAST   = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_NOTFOUND = 2'd2
    } t_status;

    // Datapath micro-operations, one per cycle
    typedef enum logic [4:0] {
        U_NOP,
        U_LOAD,
        U_TF_READ,
        U_TF_POP,
        U_NEW_FIN,
        U_NOSPACE,
        U_AP_INIT,
        U_AP_WALK,
        U_AP_SETV,
        U_AP_LINK,
        U_CL_INIT,
        U_CL_A,
        U_CL_B,
        U_CL_C,
        U_FD_INIT,
        U_FD_WALK,
        U_WP_INIT,
        U_WP_WALK,
        U_RM_A,
        U_RM_B,
        U_RM_C,
        U_TEST_HEAD,
        U_TEST_POS,
        U_OUT_LOAD
    } t_uop;

    typedef enum logic [4:0] {
        S_IDLE,
        S_TF_READ,
        S_TF_POP,
        S_NEW_FIN,
        S_AP_INIT,
        S_AP_WALK,
        S_AP_SETV,
        S_AP_LINK,
        S_CL_INIT,
        S_CL_A,
        S_CL_B,
        S_CL_C,
        S_FD_INIT,
        S_FD_WALK,
        S_WP_INIT,
        S_WP_WALK,
        S_RM_A,
        S_RM_B,
        S_RM_C,
        S_TEST_HEAD,
        S_TEST_POS,
        S_DONE
    } t_state;

    typedef struct packed {
        logic more;    // walk continues
        logic hit;     // predecessor walk found a match
        logic t_zero;  // taken node is 0: free chain empty
    } t_dp_stat;

endpackage

// File: src/cll_dpath.sv
// Datapath of the cursor linked-list engine: link and value stores, walk registers.
// Depends on cll_pkg; driven one micro-operation per cycle by cll_ctrl.
`timescale 1ns / 1ps

module cll_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cll_pkg::t_uop               i_uop,
    input  logic [cll_pkg::IDX_W-1:0]   i_list_head,
    input  logic signed [cll_pkg::VAL_W-1:0] i_value,
    input  logic [cll_pkg::IDX_W-1:0]   i_position,
    output cll_pkg::t_dp_stat           o_stat,
    output logic [1:0]                  o_status,
    output logic [cll_pkg::IDX_W-1:0]   o_node_index,
    output logic                        o_answer
);

    logic [cll_pkg::IDX_W-1:0] r_link [cll_pkg::NODE_COUNT];
    logic [cll_pkg::VAL_W-1:0] r_val  [cll_pkg::NODE_COUNT];

    cll_pkg::t_idx    r_head, r_pos, r_p, r_t, r_idx;
    cll_pkg::t_cnt    r_n;
    logic [cll_pkg::VAL_W-1:0] r_x;
    cll_pkg::t_status r_status;
    logic             r_ans;

    logic [1:0]       r_out_status;
    cll_pkg::t_idx    r_out_idx;
    logic             r_out_ans;

    cll_pkg::t_idx ra, va, rl, lk_wa, lk_wd;
    logic          lk_we;
    logic [cll_pkg::VAL_W-1:0] rv;
    logic          n_ok, v_eq;

    // single read port on each store
    always_comb begin
        case (i_uop)
            cll_pkg::U_TF_READ, cll_pkg::U_RM_B, cll_pkg::U_CL_B: ra = '0;
            cll_pkg::U_TF_POP, cll_pkg::U_RM_A:                   ra = r_t;
            cll_pkg::U_CL_INIT, cll_pkg::U_FD_INIT,
            cll_pkg::U_TEST_HEAD:                                 ra = r_head;
            cll_pkg::U_TEST_POS:                                  ra = r_pos;
            default:                                              ra = r_p;
        endcase
    end

    assign rl   = r_link[ra];
    assign va   = (i_uop == cll_pkg::U_WP_WALK) ? rl : r_p;
    assign rv   = r_val[va];
    assign v_eq = (rv == r_x);
    assign n_ok = (r_n < cll_pkg::CNT_W'(cll_pkg::NODE_COUNT));

    always_comb begin
        o_stat.more   = 1'b0;
        o_stat.hit    = 1'b0;
        o_stat.t_zero = (r_t == '0);
        case (i_uop)
            cll_pkg::U_AP_WALK: o_stat.more = n_ok && (r_p != '0) && (rl != '0);
            cll_pkg::U_CL_A:    o_stat.more = n_ok && (r_p != '0);
            cll_pkg::U_FD_WALK: o_stat.more = n_ok && (r_p != '0) && !v_eq;
            cll_pkg::U_WP_WALK: begin
                o_stat.more = n_ok && (rl != '0) && !v_eq;
                o_stat.hit  = n_ok && (rl != '0) && v_eq;
            end
            default: ;
        endcase
    end

    // link write port
    always_comb begin
        lk_we = 1'b0;
        lk_wa = '0;
        lk_wd = '0;
        case (i_uop)
            cll_pkg::U_TF_POP:  begin lk_we = 1'b1; lk_wa = '0;     lk_wd = rl;  end
            cll_pkg::U_NEW_FIN: begin lk_we = 1'b1; lk_wa = r_t;    lk_wd = '0;  end
            cll_pkg::U_AP_SETV: begin lk_we = 1'b1; lk_wa = r_t;    lk_wd = rl;  end
            cll_pkg::U_AP_LINK: begin lk_we = 1'b1; lk_wa = r_p;    lk_wd = r_t; end
            cll_pkg::U_CL_INIT: begin lk_we = 1'b1; lk_wa = r_head; lk_wd = '0;  end
            cll_pkg::U_CL_B:    begin lk_we = 1'b1; lk_wa = r_p;    lk_wd = rl;  end
            cll_pkg::U_CL_C:    begin lk_we = 1'b1; lk_wa = '0;     lk_wd = r_p; end
            cll_pkg::U_RM_A:    begin lk_we = 1'b1; lk_wa = r_p;    lk_wd = rl;  end
            cll_pkg::U_RM_B:    begin lk_we = 1'b1; lk_wa = r_t;    lk_wd = rl;  end
            cll_pkg::U_RM_C:    begin lk_we = 1'b1; lk_wa = '0;     lk_wd = r_t; end
            default: ;
        endcase
    end

    // link store: reset chains every node to the next, last to 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cll_pkg::NODE_COUNT; i++) begin
                r_link[i] <= (i == cll_pkg::NODE_COUNT - 1) ? '0 : cll_pkg::IDX_W'(i + 1);
            end
        end else if (lk_we) begin
            r_link[lk_wa] <= lk_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_uop == cll_pkg::U_AP_SETV) begin
            r_val[r_t] <= r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_uop)
            cll_pkg::U_LOAD: begin
                r_head   <= i_list_head;
                r_pos    <= i_position;
                r_x      <= i_value;
                r_status <= cll_pkg::ST_OK;
                r_idx    <= '0;
                r_ans    <= 1'b0;
            end
            cll_pkg::U_TF_READ: r_t <= rl;
            cll_pkg::U_NEW_FIN: r_idx <= r_t;
            cll_pkg::U_NOSPACE: r_status <= cll_pkg::ST_NOSPACE;
            cll_pkg::U_AP_INIT, cll_pkg::U_WP_INIT: begin
                r_p <= r_head;
                r_n <= '0;
            end
            cll_pkg::U_AP_WALK: begin
                if (o_stat.more) begin
                    r_p <= rl;
                    r_n <= r_n + cll_pkg::CNT_W'(1);
                end
            end
            cll_pkg::U_AP_LINK: r_idx <= r_t;
            cll_pkg::U_CL_INIT, cll_pkg::U_FD_INIT: begin
                r_p <= rl;
                r_n <= '0;
            end
            cll_pkg::U_CL_A: r_t <= rl;
            cll_pkg::U_CL_C: begin
                r_p <= r_t;
                r_n <= r_n + cll_pkg::CNT_W'(1);
            end
            cll_pkg::U_FD_WALK: begin
                if (o_stat.more) begin
                    r_p <= rl;
                    r_n <= r_n + cll_pkg::CNT_W'(1);
                end else if ((r_p != '0) && v_eq) begin
                    r_idx <= r_p;
                end else begin
                    r_status <= cll_pkg::ST_NOTFOUND;
                end
            end
            cll_pkg::U_WP_WALK: begin
                if (o_stat.more) begin
                    r_p <= rl;
                    r_n <= r_n + cll_pkg::CNT_W'(1);
                end else if (o_stat.hit) begin
                    // predecessor result; a removal overwrites it at the end
                    r_t   <= rl;
                    r_idx <= r_p;
                end else begin
                    r_status <= cll_pkg::ST_NOTFOUND;
                end
            end
            cll_pkg::U_RM_C: r_idx <= r_t;
            cll_pkg::U_TEST_HEAD, cll_pkg::U_TEST_POS: r_ans <= (rl == '0);
            cll_pkg::U_OUT_LOAD: begin
                r_out_status <= r_status;
                r_out_idx    <= r_idx;
                r_out_ans    <= r_ans;
            end
            default: ;
        endcase
    end

    assign o_status     = r_out_status;
    assign o_node_index = r_out_idx;
    assign o_answer     = r_out_ans;

endmodule

// File: src/cll_ctrl.sv
// Sequencer of the cursor linked-list engine: handshakes and micro-operation order.
// Depends on cll_pkg; commands cll_dpath.
`timescale 1ns / 1ps

module cll_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_op,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  cll_pkg::t_dp_stat i_stat,
    output cll_pkg::t_uop     o_uop
);

    cll_pkg::t_state r_state, n_state;
    cll_pkg::t_op    r_op, n_op;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cll_pkg::S_IDLE;
            r_op        <= cll_pkg::OP_NEW;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_out_valid = r_out_valid && !i_out_ready;
        o_uop       = cll_pkg::U_NOP;
        o_in_ready  = 1'b0;
        case (r_state)
            cll_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_uop = cll_pkg::U_LOAD;
                    n_op  = cll_pkg::t_op'(i_op);
                    case (cll_pkg::t_op'(i_op))
                        cll_pkg::OP_NEW, cll_pkg::OP_APPEND:
                            n_state = cll_pkg::S_TF_READ;
                        cll_pkg::OP_CLEAR:
                            n_state = cll_pkg::S_CL_INIT;
                        cll_pkg::OP_FIND:
                            n_state = cll_pkg::S_FD_INIT;
                        cll_pkg::OP_FIND_PREV, cll_pkg::OP_REMOVE:
                            n_state = cll_pkg::S_WP_INIT;
                        cll_pkg::OP_IS_EMPTY:
                            n_state = cll_pkg::S_TEST_HEAD;
                        default:
                            n_state = cll_pkg::S_TEST_POS;
                    endcase
                end
            end
            cll_pkg::S_TF_READ: begin
                o_uop   = cll_pkg::U_TF_READ;
                n_state = cll_pkg::S_TF_POP;
            end
            cll_pkg::S_TF_POP: begin
                if (i_stat.t_zero) begin
                    o_uop   = cll_pkg::U_NOSPACE;
                    n_state = cll_pkg::S_DONE;
                end else begin
                    o_uop   = cll_pkg::U_TF_POP;
                    n_state = (r_op == cll_pkg::OP_NEW) ? cll_pkg::S_NEW_FIN
                                                        : cll_pkg::S_AP_INIT;
                end
            end
            cll_pkg::S_NEW_FIN: begin
                o_uop   = cll_pkg::U_NEW_FIN;
                n_state = cll_pkg::S_DONE;
            end
            cll_pkg::S_AP_INIT: begin
                o_uop   = cll_pkg::U_AP_INIT;
                n_state = cll_pkg::S_AP_WALK;
            end
            cll_pkg::S_AP_WALK: begin
                o_uop = cll_pkg::U_AP_WALK;
                if (!i_stat.more) begin
                    n_state = cll_pkg::S_AP_SETV;
                end
            end
            cll_pkg::S_AP_SETV: begin
                o_uop   = cll_pkg::U_AP_SETV;
                n_state = cll_pkg::S_AP_LINK;
            end
            cll_pkg::S_AP_LINK: begin
                o_uop   = cll_pkg::U_AP_LINK;
                n_state = cll_pkg::S_DONE;
            end
            cll_pkg::S_CL_INIT: begin
                o_uop   = cll_pkg::U_CL_INIT;
                n_state = cll_pkg::S_CL_A;
            end
            cll_pkg::S_CL_A: begin
                o_uop   = cll_pkg::U_CL_A;
                n_state = i_stat.more ? cll_pkg::S_CL_B : cll_pkg::S_DONE;
            end
            cll_pkg::S_CL_B: begin
                o_uop   = cll_pkg::U_CL_B;
                n_state = cll_pkg::S_CL_C;
            end
            cll_pkg::S_CL_C: begin
                o_uop   = cll_pkg::U_CL_C;
                n_state = cll_pkg::S_CL_A;
            end
            cll_pkg::S_FD_INIT: begin
                o_uop   = cll_pkg::U_FD_INIT;
                n_state = cll_pkg::S_FD_WALK;
            end
            cll_pkg::S_FD_WALK: begin
                o_uop = cll_pkg::U_FD_WALK;
                if (!i_stat.more) begin
                    n_state = cll_pkg::S_DONE;
                end
            end
            cll_pkg::S_WP_INIT: begin
                o_uop   = cll_pkg::U_WP_INIT;
                n_state = cll_pkg::S_WP_WALK;
            end
            cll_pkg::S_WP_WALK: begin
                o_uop = cll_pkg::U_WP_WALK;
                if (!i_stat.more) begin
                    n_state = (i_stat.hit && (r_op == cll_pkg::OP_REMOVE))
                              ? cll_pkg::S_RM_A : cll_pkg::S_DONE;
                end
            end
            cll_pkg::S_RM_A: begin
                o_uop   = cll_pkg::U_RM_A;
                n_state = cll_pkg::S_RM_B;
            end
            cll_pkg::S_RM_B: begin
                o_uop   = cll_pkg::U_RM_B;
                n_state = cll_pkg::S_RM_C;
            end
            cll_pkg::S_RM_C: begin
                o_uop   = cll_pkg::U_RM_C;
                n_state = cll_pkg::S_DONE;
            end
            cll_pkg::S_TEST_HEAD: begin
                o_uop   = cll_pkg::U_TEST_HEAD;
                n_state = cll_pkg::S_DONE;
            end
            cll_pkg::S_TEST_POS: begin
                o_uop   = cll_pkg::U_TEST_POS;
                n_state = cll_pkg::S_DONE;
            end
            cll_pkg::S_DONE: begin
                // hand over once the output register is free or being emptied
                if (!r_out_valid || i_out_ready) begin
                    o_uop       = cll_pkg::U_OUT_LOAD;
                    n_out_valid = 1'b1;
                    n_state     = cll_pkg::S_IDLE;
                end
            end
            default: n_state = cll_pkg::S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: src/cursor_linked_list_engine.sv
// Top level of the cursor linked-list engine: sequencer plus datapath.
// Depends on cll_pkg, cll_ctrl and cll_dpath.
`timescale 1ns / 1ps

// Usage
//  - Request channel (i_in_valid / o_in_ready) carries op, list_head, value and
//    position. One transfer is one request; every request yields exactly one
//    result transfer on the result channel (o_out_valid / i_out_ready) with
//    status, node_index and answer.
//  - One request is in work at a time; o_in_ready is high only while idle.
//  - Walks are bounded at NODE_COUNT links, so a clear of a long list is the
//    longest operation. The pace is set by the single read port and single
//    write port of the link store: one link step per cycle, and each node
//    handed back to the free chain takes three steps (CL_A, CL_B, CL_C).
//  - The result sits in an output register, so the next request is taken while
//    a result is still waiting; a stalled receiver only holds the sequencer
//    at its hand-over step once the following result is ready.
//  - Synchronous active-low reset empties the output register and links every
//    node to the next, so node 0 heads a free chain of all other nodes.
//    Node values are undefined until an append writes them.

module cursor_linked_list_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [2:0]                        i_op,
    input  logic [cll_pkg::IDX_W-1:0]         i_list_head,
    input  logic signed [cll_pkg::VAL_W-1:0]  i_value,
    input  logic [cll_pkg::IDX_W-1:0]         i_position,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_status,
    output logic [cll_pkg::IDX_W-1:0]         o_node_index,
    output logic                              o_answer
);

    cll_pkg::t_uop     uop;
    cll_pkg::t_dp_stat dp_stat;

    cll_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_uop       (uop)
    );

    cll_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_uop        (uop),
        .i_list_head  (i_list_head),
        .i_value      (i_value),
        .i_position   (i_position),
        .o_stat       (dp_stat),
        .o_status     (o_status),
        .o_node_index (o_node_index),
        .o_answer     (o_answer)
    );

endmodule
